// ===== design/bmm_pkg.sv =====
// Shared types and constants of the banked memory mapper.
package bmm_pkg;

  // Access kinds on the action field.
  localparam logic ActRead  = 1'b0;
  localparam logic ActWrite = 1'b1;

  // Configuration register indexes.
  localparam logic [0:0] CfgCodeMode  = 1'd0;
  localparam logic [0:0] CfgLargeCart = 1'd1;

  // Slot numbers from address bits 15:14.
  localparam logic [1:0] SlotRom0 = 2'd0;
  localparam logic [1:0] SlotRom1 = 2'd1;
  localparam logic [1:0] SlotCart = 2'd2;
  localparam logic [1:0] SlotSys  = 2'd3;

  localparam int unsigned SlotBytes = 16384;
  localparam int unsigned SlotAw    = 14;
  localparam int unsigned RomAw     = 20;

  // Control register addresses of the normal paging mode.
  localparam logic [15:0] AddrRamCtrl = 16'hFFFC;
  localparam logic [15:0] AddrPage0   = 16'hFFFD;
  localparam logic [15:0] AddrPage1   = 16'hFFFE;
  localparam logic [15:0] AddrPage2   = 16'hFFFF;

  // Bits of the RAM control byte.
  localparam int unsigned CtrlEnBit   = 3;
  localparam int unsigned CtrlBankBit = 2;

  typedef struct packed {
    logic        action;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_word_t;

  typedef struct packed {
    logic [7:0]       read_data;
    logic             rom_fetch;
    logic [RomAw-1:0] rom_address;
  } out_word_t;

endpackage

// ===== design/bmm_intf.sv =====
// Valid/ready channel interfaces for bus accesses and mapper results.
interface bmm_in_if;
  logic               valid;
  logic               ready;
  bmm_pkg::in_word_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface bmm_out_if;
  logic               valid;
  logic               ready;
  bmm_pkg::out_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/banked_memory_mapper.sv =====
// Banked memory mapper: each accepted bus access word yields one result word.
// Reads of system RAM or cartridge RAM return the byte; reads of the ROM slots,
// and of the cartridge slot while its RAM is disabled, return rom_fetch and the
// physical ROM address; writes return an all-zero word. The block takes one
// access per cycle as long as results are taken; the RAMs and the read stage are
// loaded when an access is accepted, the output register when the read stage moves
// on. After reset a clearing pass zeroes both RAMs, one entry per cycle, while its
// counter steps over CART_RAM_BANKS * 16384 addresses; no access is taken during it, configuration writes are.
module banked_memory_mapper #(
  parameter int unsigned SYS_RAM_BYTES  = 8192,
  parameter int unsigned CART_RAM_BANKS = 2,
  parameter int unsigned PAGE_BITS      = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [0:0] cfg_data_i,
  bmm_in_if.sink     in_i,
  bmm_out_if.source  out_o
);

  localparam int unsigned SysAw     = $clog2(SYS_RAM_BYTES);
  localparam int unsigned CartDepth = CART_RAM_BANKS * bmm_pkg::SlotBytes;
  localparam int unsigned CartAw    = $clog2(CartDepth);
  localparam int unsigned SysFolds  = (bmm_pkg::SlotBytes - 1) / SYS_RAM_BYTES;
  localparam logic [PAGE_BITS-1:0] PageMaskSmall = {1'b0, {(PAGE_BITS-1){1'b1}}};

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_SYS,
    RES_CART,
    RES_ROM
  } res_e;

  // Configuration.
  logic mode_q, large_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      large_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bmm_pkg::CfgCodeMode:  mode_q  <= cfg_data_i[0];
        bmm_pkg::CfgLargeCart: large_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Clearing pass after reset.
  logic              clr_q, clr_d;
  logic [CartAw-1:0] clr_cnt_q, clr_cnt_d;

  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == CartAw'(CartDepth - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // Pipeline handshake.
  logic s1_valid_q, s1_valid_d;
  res_e s1_kind_q;
  logic [bmm_pkg::RomAw-1:0] s1_rom_q;
  logic out_valid_q, out_valid_d;
  logic out_free, in_acc, s1_move;

  assign out_free    = !out_valid_q || out_o.ready;
  assign in_i.ready  = !clr_q && (!s1_valid_q || out_free);
  assign in_acc      = in_i.valid && in_i.ready;
  assign s1_move     = s1_valid_q && out_free;

  // Decode of the accepted access.
  logic [15:0]               addr;
  logic [1:0]                slot;
  logic [bmm_pkg::SlotAw-1:0] offset;
  logic                      is_wr;
  logic [7:0]                wdata;
  logic [PAGE_BITS-1:0]      page_new;
  logic [PAGE_BITS-1:0]      page_q [3];
  logic                      ram_en_q, ram_bank_q;
  logic                      bank_eff;
  logic [CartAw-1:0]         cart_idx;
  logic [bmm_pkg::SlotAw-1:0] sys_base;
  logic [bmm_pkg::SlotAw-1:0] sys_rem;
  logic [SysAw-1:0]          sys_idx;
  logic [PAGE_BITS-1:0]      rd_page;
  res_e                      kind;
  logic [bmm_pkg::RomAw-1:0] rom_addr;

  assign addr     = in_i.payload.address;
  assign slot     = addr[15:14];
  assign offset   = addr[bmm_pkg::SlotAw-1:0];
  assign is_wr    = (in_i.payload.action == bmm_pkg::ActWrite);
  assign wdata    = in_i.payload.write_data;
  assign page_new = PAGE_BITS'(wdata) & (large_q ? {PAGE_BITS{1'b1}} : PageMaskSmall);
  assign bank_eff = (CART_RAM_BANKS > 1) ? ram_bank_q : 1'b0;
  assign cart_idx = CartAw'({bank_eff, offset});

  // System RAM mirror: the slot offset is folded by constant multiples of the
  // RAM size, each compare independent of the others.
  always_comb begin
    sys_base = '0;
    for (int k = 1; k <= int'(SysFolds); k++) begin
      if ({18'd0, offset} >= 32'(k * SYS_RAM_BYTES)) begin
        sys_base = bmm_pkg::SlotAw'(k * SYS_RAM_BYTES);
      end
    end
    sys_rem = offset - sys_base;
  end
  assign sys_idx = SysAw'(sys_rem);

  always_comb begin
    case (slot)
      bmm_pkg::SlotRom0: rd_page = page_q[0];
      bmm_pkg::SlotRom1: rd_page = page_q[1];
      default:           rd_page = page_q[2];
    endcase
  end

  always_comb begin
    kind     = RES_ZERO;
    rom_addr = '0;
    if (!is_wr) begin
      if (slot == bmm_pkg::SlotSys) begin
        kind = RES_SYS;
      end else if (slot == bmm_pkg::SlotCart && ram_en_q) begin
        kind = RES_CART;
      end else begin
        kind     = RES_ROM;
        rom_addr = bmm_pkg::RomAw'({rd_page, offset});
      end
    end
  end

  // Mapper registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q[0]  <= PAGE_BITS'(0);
      page_q[1]  <= PAGE_BITS'(1);
      page_q[2]  <= PAGE_BITS'(2);
      ram_en_q   <= 1'b0;
      ram_bank_q <= 1'b0;
    end else if (in_acc && is_wr) begin
      if (mode_q) begin
        if (offset == '0) begin
          case (slot)
            bmm_pkg::SlotRom0: page_q[0] <= page_new;
            bmm_pkg::SlotRom1: page_q[1] <= page_new;
            bmm_pkg::SlotCart: page_q[2] <= page_new;
            default: ;
          endcase
        end
      end else begin
        case (addr)
          bmm_pkg::AddrRamCtrl: begin
            ram_en_q   <= wdata[bmm_pkg::CtrlEnBit];
            ram_bank_q <= wdata[bmm_pkg::CtrlBankBit];
          end
          bmm_pkg::AddrPage0: page_q[0] <= page_new;
          bmm_pkg::AddrPage1: page_q[1] <= page_new;
          bmm_pkg::AddrPage2: page_q[2] <= page_new;
          default: ;
        endcase
      end
    end
  end

  // System RAM.
  logic [7:0]       sys_ram [SYS_RAM_BYTES];
  logic [7:0]       sys_rdata_q;
  logic             sys_we, sys_re;
  logic [SysAw-1:0] sys_waddr;
  logic [7:0]       sys_wdata;

  assign sys_re = in_acc && (kind == RES_SYS);

  always_comb begin
    sys_we    = 1'b0;
    sys_waddr = sys_idx;
    sys_wdata = wdata;
    if (clr_q) begin
      sys_we    = ({{(32 - CartAw){1'b0}}, clr_cnt_q} < 32'(SYS_RAM_BYTES));
      sys_waddr = SysAw'(clr_cnt_q);
      sys_wdata = '0;
    end else if (in_acc && is_wr && slot == bmm_pkg::SlotSys) begin
      sys_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sys_we) begin
      sys_ram[sys_waddr] <= sys_wdata;
    end
    if (sys_re) begin
      sys_rdata_q <= sys_ram[sys_idx];
    end
  end

  // Cartridge RAM.
  logic [7:0]        cart_ram [CartDepth];
  logic [7:0]        cart_rdata_q;
  logic              cart_we, cart_re;
  logic [CartAw-1:0] cart_waddr;
  logic [7:0]        cart_wdata;

  assign cart_re = in_acc && (kind == RES_CART);

  always_comb begin
    cart_we    = 1'b0;
    cart_waddr = cart_idx;
    cart_wdata = wdata;
    if (clr_q) begin
      cart_we    = 1'b1;
      cart_waddr = clr_cnt_q;
      cart_wdata = '0;
    end else if (in_acc && is_wr && slot == bmm_pkg::SlotCart && ram_en_q) begin
      cart_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cart_we) begin
      cart_ram[cart_waddr] <= cart_wdata;
    end
    if (cart_re) begin
      cart_rdata_q <= cart_ram[cart_idx];
    end
  end

  // Read stage and output register.
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  bmm_pkg::out_word_t out_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_kind_q <= kind;
      s1_rom_q  <= rom_addr;
    end
    if (s1_move) begin
      case (s1_kind_q)
        RES_SYS:  out_q.read_data <= sys_rdata_q;
        RES_CART: out_q.read_data <= cart_rdata_q;
        default:  out_q.read_data <= '0;
      endcase
      out_q.rom_fetch   <= (s1_kind_q == RES_ROM);
      out_q.rom_address <= s1_rom_q;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // Nothing is in flight while the RAMs are being cleared.
  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> (!s1_valid_q && !out_valid_q))
    else $error("access in flight during RAM clearing");

  // A write access always produces the all-zero result.
  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_wr) |=> (s1_valid_q && s1_kind_q == RES_ZERO && s1_rom_q == '0))
    else $error("write access did not yield a zero result");

  // A waiting read stage is never dropped while the output is stalled.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_free) |=> s1_valid_q)
    else $error("read stage lost while output stalled");

  // A ROM fetch result never carries RAM data.
  a_rom_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.rom_fetch) |-> (out_q.read_data == '0))
    else $error("ROM fetch result carries read data");

endmodule
